// ----- rtl/core/rpip_pkg.sv -----
// shared types and character codes for the radix-prefixed integer parser
package rpip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_LO    = 8'h6f;  // 'o'
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;  // 'x'

  localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_ZERO   = 3'd1,
    MODE_DEC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_OCT    = 3'd4,
    MODE_BIN    = 3'd5,
    MODE_IGNORE = 3'd6,
    MODE_ERR    = 3'd7
  } mode_t;

  // digit classes of one character and its digit value
  typedef struct packed {
    logic                 dec_ok;
    logic                 hex_ok;
    logic                 oct_ok;
    logic                 bin_ok;
    logic [DIGIT_W-1:0]   val;
  } digit_t;

  // result of one string
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               bad;
  } result_t;

endpackage

// ----- rtl/core/rpip_digit.sv -----
// character classifier: which radixes accept a character and its digit value
module rpip_digit (
  input  logic [rpip_pkg::CHAR_W-1:0] ch,
  output rpip_pkg::digit_t            dig
);
  import rpip_pkg::*;

  logic is_dec;
  logic is_upper;
  logic is_lower;
  logic [CHAR_W-1:0] dec_off;
  logic [CHAR_W-1:0] up_off;
  logic [CHAR_W-1:0] lo_off;

  always_comb begin
    is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_upper = (ch >= CH_UA) && (ch <= CH_UF);
    is_lower = (ch >= CH_LA) && (ch <= CH_LF);
    dec_off  = ch - CH_ZERO;
    up_off   = ch - CH_UA;
    lo_off   = ch - CH_LA;

    dig.dec_ok = is_dec;
    dig.hex_ok = is_dec || is_upper || is_lower;
    dig.oct_ok = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
    dig.bin_ok = (ch == CH_ZERO) || (ch == CH_ONE);

    if (is_upper) begin
      dig.val = HEX_LETTER_BASE + up_off[DIGIT_W-1:0];
    end else if (is_lower) begin
      dig.val = HEX_LETTER_BASE + lo_off[DIGIT_W-1:0];
    end else begin
      dig.val = dec_off[DIGIT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/rpip_core.sv -----
// parse state machine and 64-bit accumulator, one character per advance
module rpip_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [rpip_pkg::CHAR_W-1:0] ch,
  output rpip_pkg::result_t           res
);
  import rpip_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;
  digit_t             dig;
  logic [VALUE_W-1:0] dec_acc;
  logic [VALUE_W-1:0] hex_acc;
  logic [VALUE_W-1:0] oct_acc;
  logic [VALUE_W-1:0] bin_acc;

  rpip_digit u_digit (
    .ch  (ch),
    .dig (dig)
  );

  // acc * 10 + d as (acc << 3) + (acc << 1) + d
  assign dec_acc = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0}
                   + {{(VALUE_W-DIGIT_W){1'b0}}, dig.val};
  assign hex_acc = {acc[VALUE_W-5:0], dig.val};
  assign oct_acc = {acc[VALUE_W-4:0], dig.val[2:0]};
  assign bin_acc = {acc[VALUE_W-2:0], dig.val[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      acc  <= '0;
    end else if (adv) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    res.value = ((mode == MODE_ERR) || (mode == MODE_IGNORE)) ? '0 : acc;
    res.bad   = (mode == MODE_ERR);

    if (ch == CH_NUL) begin
      mode_next = MODE_START;
      acc_next  = '0;
    end else begin
      unique case (mode) inside
        MODE_START: begin
          if (ch == CH_ZERO) begin
            mode_next = MODE_ZERO;
          end else if (dig.dec_ok) begin
            mode_next = MODE_DEC;
            acc_next  = dec_acc;
          end else begin
            mode_next = MODE_ERR;
          end
        end
        MODE_ZERO: begin
          if (ch == CH_LX) begin
            mode_next = MODE_HEX;
          end else if (ch == CH_LO) begin
            mode_next = MODE_OCT;
          end else if (dig.dec_ok) begin
            // digit after the leading zero is the first octal digit
            if (dig.oct_ok) begin
              mode_next = MODE_OCT;
              acc_next  = oct_acc;
            end else begin
              mode_next = MODE_ERR;
            end
          end else if (ch == CH_LB) begin
            mode_next = MODE_BIN;
          end else begin
            mode_next = MODE_IGNORE;
            acc_next  = '0;
          end
        end
        MODE_DEC: begin
          if (dig.dec_ok) acc_next = dec_acc;
          else            mode_next = MODE_ERR;
        end
        MODE_HEX: begin
          if (dig.hex_ok) acc_next = hex_acc;
          else            mode_next = MODE_ERR;
        end
        MODE_OCT: begin
          if (dig.oct_ok) acc_next = oct_acc;
          else            mode_next = MODE_ERR;
        end
        MODE_BIN: begin
          if (dig.bin_ok) acc_next = bin_acc;
          else            mode_next = MODE_ERR;
        end
        MODE_IGNORE, MODE_ERR: begin
          mode_next = mode;
        end
        default: begin
          mode_next = MODE_ERR;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/radix_prefixed_integer_parser.sv -----
// top level: character input register, parse core and result register
//
// Radix-prefixed integer parser. One ASCII character is taken per request
// on the chr channel; a NUL character ends the string and produces exactly
// one request on the result channel carrying the 64-bit value (modulo
// 2^64) and a bad flag. A leading '0' selects the radix from the next
// character: 'x' hex, 'o' octal, 'b' binary, a digit 0-7 octal with that
// digit counted, 8 or 9 a bad result; any other character there gives
// value 0 and the rest of the string is skipped. Without a leading '0' the
// string is decimal. A character that is not a digit of the radix makes
// the result bad with value 0. Throughput is one character per clock: the
// state update is a single shift-and-add on the 64-bit accumulator between
// the character register and the state register; only a NUL waits in the
// character register, and only while an earlier result is still held by
// result_stall. A NUL passes the character and result registers in turn.
module radix_prefixed_integer_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         chr_valid,
  output logic                         chr_stall,
  input  logic [rpip_pkg::CHAR_W-1:0]  ch,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [rpip_pkg::VALUE_W-1:0] value,
  output logic                         bad
);
  import rpip_pkg::*;

  // character register
  logic              ch_reg_valid;
  logic [CHAR_W-1:0] ch_reg;
  // advance the parse core with the held character
  logic              adv;
  logic              is_nul;
  logic              res_free;
  result_t           res;

  assign is_nul   = (ch_reg == CH_NUL);
  // result slot can take a new result this cycle
  assign res_free = !result_valid || !result_stall;
  // only a terminating NUL needs room at the output
  assign adv       = ch_reg_valid && (!is_nul || res_free);
  assign chr_stall = ch_reg_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_reg_valid <= 1'b0;
    end else if (!chr_stall) begin
      ch_reg_valid <= chr_valid;
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (!chr_stall && chr_valid) begin
      ch_reg <= ch;
    end
  end

  rpip_core u_core (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .ch  (ch_reg),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && is_nul) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_nul) begin
      value <= res.value;
      bad   <= res.bad;
    end
  end

`ifndef SYNTHESIS
  // a bad result always reports zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!bad || (value == '0)))
    else $error("bad result with nonzero value");

  // a held character is neither lost nor changed
  assert property (@(posedge clk) disable iff (rst)
    (ch_reg_valid && !adv) |=> (ch_reg_valid && $stable(ch_reg)))
    else $error("held character dropped or changed");

  // a NUL never overwrites a result that is still stalled
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(adv && is_nul))
    else $error("stalled result overwritten");

  // a non-NUL character never produces a new result
  assert property (@(posedge clk) disable iff (rst)
    (adv && !is_nul && !result_valid) |=> !result_valid)
    else $error("result produced without terminator");
`endif

endmodule
